// File: src/asoa_pkg.sv
// Shared types and constants for the ADC scan oversample accumulator.
// Used by the front, queue, back and top-level modules; depends on nothing.
package asoa_pkg;

    // Default slot count of the scan
    localparam int NUM_SLOTS_DEF = 8;

    // Field widths fixed by the interface
    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 16;
    localparam int CHAN_W   = 4;
    localparam int MASK_W   = 16;
    localparam int ROUNDS_W = 8;
    localparam int KIND_W   = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLE_ROUNDS = 1'b1;

    // Configuration reset values
    localparam logic [MASK_W-1:0]   MASK_RST   = 16'h00FF;
    localparam logic [ROUNDS_W-1:0] ROUNDS_RST = 8'd8;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MUX   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUM   = 2'd2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    // One classified tick handed from front to back
    typedef struct packed {
        logic                is_start;
        logic [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]   slot;
        logic                dump;
        logic [CHAN_W-1:0]   chan;
    } t_cmd;

endpackage

// File: src/adc_scan_oversample_accumulator.sv
// Top level of the ADC scan oversample accumulator: configuration
// registers, front end, command queue and back end. Depends on asoa_pkg.
//
// Usage: each accepted input word on i_valid/o_ready is one tick. Ticks
// alternate between a start tick (one start-conversion word out) and a
// sample tick (i_sample is added to the current slot's sum, then one
// mux-select word out). After the configured number of full rounds a
// sample tick first emits one sum word per slot, in slot order, and
// clears the sums. o_last marks the final word of each tick.
// An accepted word is written into the queue and popped by the back end in
// its idle state. A start tick then passes the start state; a sample tick
// passes the accumulate state, a read and a sum-output state per slot when
// sums are emitted, and the mux state. The back-end sequencer reads the sum
// memory through one registered port and pops a new tick only when idle. A
// two-entry queue lets the front take new words while the back is busy.
// Configuration words on i_cfg_we are taken in one cycle and must only
// be written while the block is idle. Reset clears phase, slot, round
// count, queue and sums (per-slot valid bits) and loads the register
// defaults. When the receiver holds i_ready low the output word holds,
// the back end stops, and the queue fills until o_ready drops.
module adc_scan_oversample_accumulator #(
    parameter int NUM_SLOTS = asoa_pkg::NUM_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [asoa_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [asoa_pkg::KIND_W-1:0]       o_kind,
    output logic [asoa_pkg::CHAN_W-1:0]       o_mux_channel,
    output logic [asoa_pkg::CHAN_W-1:0]       o_sum_slot,
    output logic [asoa_pkg::SUM_W-1:0]        o_sum_value,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [asoa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [asoa_pkg::MASK_W-1:0]       i_cfg_data
);

    logic [asoa_pkg::MASK_W-1:0]     r_channel_mask;
    logic [asoa_pkg::ROUNDS_W-1:0]   r_oversample_rounds;
    logic                            w_push;
    asoa_pkg::t_cmd                  w_push_cmd;
    logic                            w_q_full;
    logic                            w_q_empty;
    logic                            w_pop;
    asoa_pkg::t_cmd                  w_pop_cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_mask      <= asoa_pkg::MASK_RST;
            r_oversample_rounds <= asoa_pkg::ROUNDS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                asoa_pkg::CFG_CHANNEL_MASK: begin
                    r_channel_mask <= i_cfg_data;
                end
                asoa_pkg::CFG_OVERSAMPLE_ROUNDS: begin
                    r_oversample_rounds <= i_cfg_data[asoa_pkg::ROUNDS_W-1:0];
                end
                default: begin
                    r_channel_mask <= r_channel_mask;
                end
            endcase
        end
    end

    asoa_front #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_sample            (i_sample),
        .i_channel_mask      (r_channel_mask),
        .i_oversample_rounds (r_oversample_rounds),
        .i_q_full            (w_q_full),
        .o_push              (w_push),
        .o_cmd               (w_push_cmd)
    );

    asoa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_data  (w_pop_cmd)
    );

    asoa_back #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_data      (w_pop_cmd),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_mux_channel (o_mux_channel),
        .o_sum_slot    (o_sum_slot),
        .o_sum_value   (o_sum_value),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    // A start word is always the only word of its tick
    a_start_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == asoa_pkg::KIND_START)) |-> o_last)
        else $error("start word without last");

    // A sum word is never the final word of its tick
    a_sum_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == asoa_pkg::KIND_SUM)) |-> !o_last)
        else $error("sum word marked last");

    // Only sum words carry a sum value
    a_sum_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind != asoa_pkg::KIND_SUM)) |-> (o_sum_value == '0))
        else $error("non-sum word carries a sum value");

    // The queue never takes a word while full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_push)
        else $error("push into full queue");
`endif

endmodule

// File: src/asoa_front.sv
// Front end: accepts input words, tracks phase, slot and round count,
// and turns each tick into a command. Depends on asoa_pkg.
module asoa_front #(
    parameter int NUM_SLOTS = asoa_pkg::NUM_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [asoa_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic [asoa_pkg::MASK_W-1:0]       i_channel_mask,
    input  logic [asoa_pkg::ROUNDS_W-1:0]     i_oversample_rounds,
    input  logic                              i_q_full,
    output logic                              o_push,
    output asoa_pkg::t_cmd                    o_cmd
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic                            r_phase;
    logic                            n_phase;
    logic [SLOT_W-1:0]               r_slot;
    logic [SLOT_W-1:0]               n_slot;
    logic [asoa_pkg::ROUNDS_W-1:0]   r_round;
    logic [asoa_pkg::ROUNDS_W-1:0]   n_round;
    logic                            w_wrap;
    logic [SLOT_W-1:0]               w_slot_nx;
    logic [asoa_pkg::ROUNDS_W-1:0]   w_round_inc;
    logic                            w_dump;
    logic [asoa_pkg::CHAN_W-1:0]     w_slot4;
    logic [asoa_pkg::CHAN_W:0]       w_pre [asoa_pkg::MASK_W];
    logic [asoa_pkg::CHAN_W-1:0]     w_chan;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;

    // Slot advance and round bookkeeping
    assign w_wrap      = (r_slot == SLOT_W'(NUM_SLOTS - 1));
    assign w_slot_nx   = w_wrap ? '0 : r_slot + 1'b1;
    assign w_round_inc = r_round + 1'b1;
    assign w_dump      = w_wrap && (w_round_inc >= i_oversample_rounds);
    assign w_slot4     = asoa_pkg::CHAN_W'(w_slot_nx);

    // Pick the set bit of the mask whose rank is the next slot; channel 0 when too few bits
    always_comb begin
        w_chan = '0;
        for (int c = 0; c < asoa_pkg::MASK_W; c++) begin
            w_pre[c] = asoa_pkg::CHAN_W'(0) + (asoa_pkg::CHAN_W + 1)'($countones(
                       i_channel_mask & ((asoa_pkg::MASK_W'(1) << c) - 1'b1)));
            if (i_channel_mask[c] && (w_pre[c] == {1'b0, w_slot4})) begin
                w_chan = w_chan | asoa_pkg::CHAN_W'(c);
            end
        end
    end

    // Build the command for this tick
    always_comb begin
        o_cmd          = '0;
        o_cmd.is_start = !r_phase;
        o_cmd.sample   = i_sample;
        o_cmd.slot     = asoa_pkg::CHAN_W'(r_slot);
        o_cmd.dump     = w_dump;
        o_cmd.chan     = w_chan;
    end

    // Next state of the scan
    always_comb begin
        n_phase = r_phase;
        n_slot  = r_slot;
        n_round = r_round;
        if (o_push) begin
            n_phase = !r_phase;
            if (r_phase) begin
                n_slot = w_slot_nx;
                if (w_wrap) begin
                    n_round = w_dump ? '0 : w_round_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_slot  <= '0;
            r_round <= '0;
        end else begin
            r_phase <= n_phase;
            r_slot  <= n_slot;
            r_round <= n_round;
        end
    end

endmodule

// File: src/asoa_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on asoa_pkg for the command type and depth.
module asoa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  asoa_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output asoa_pkg::t_cmd  o_data
);

    asoa_pkg::t_cmd                  r_mem [asoa_pkg::QUEUE_DEPTH];
    logic [asoa_pkg::QUEUE_AW-1:0]   r_wp;
    logic [asoa_pkg::QUEUE_AW-1:0]   r_rp;
    logic [asoa_pkg::QUEUE_AW:0]     r_cnt;
    logic                            w_wr;
    logic                            w_rd;

    assign o_full  = (r_cnt == (asoa_pkg::QUEUE_AW + 1)'(asoa_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: src/asoa_back.sv
// Back end: carries out commands, holds the per-slot sums in a small
// memory and drives the output register. Depends on asoa_pkg.
module asoa_back #(
    parameter int NUM_SLOTS = asoa_pkg::NUM_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  asoa_pkg::t_cmd                  i_q_data,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [asoa_pkg::KIND_W-1:0]     o_kind,
    output logic [asoa_pkg::CHAN_W-1:0]     o_mux_channel,
    output logic [asoa_pkg::CHAN_W-1:0]     o_sum_slot,
    output logic [asoa_pkg::SUM_W-1:0]      o_sum_value,
    output logic                            o_last
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_DRD   = 3'd2;
    localparam logic [2:0] S_DOUT  = 3'd3;
    localparam logic [2:0] S_MUX   = 3'd4;
    localparam logic [2:0] S_START = 3'd5;

    logic [2:0]                      r_state;
    logic [2:0]                      n_state;
    asoa_pkg::t_cmd                  r_cmd;
    logic [AW-1:0]                   r_idx;
    logic [AW-1:0]                   n_idx;
    logic [asoa_pkg::SUM_W-1:0]      r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]            r_vld;
    logic [asoa_pkg::SUM_W-1:0]      r_rdata;
    logic                            r_rdv;
    logic [AW-1:0]                   w_raddr;
    logic [asoa_pkg::SUM_W-1:0]      w_rval;
    logic [AW-1:0]                   w_cmd_addr;
    logic                            w_we;
    logic                            w_clr;
    logic                            w_out_free;
    logic                            w_load;
    logic [asoa_pkg::KIND_W-1:0]     w_kind;
    logic [asoa_pkg::CHAN_W-1:0]     w_mux;
    logic [asoa_pkg::CHAN_W-1:0]     w_slot;
    logic [asoa_pkg::SUM_W-1:0]      w_value;
    logic                            w_last;

    assign w_out_free = !o_valid || i_ready;
    assign w_cmd_addr = r_cmd.slot[AW-1:0];
    assign w_raddr    = (r_state == S_IDLE) ? i_q_data.slot[AW-1:0] : r_idx;
    assign w_rval     = r_rdv ? r_rdata : '0;
    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;

    // Sequence commands and pick the next result
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        w_we    = 1'b0;
        w_clr   = 1'b0;
        w_load  = 1'b0;
        w_kind  = asoa_pkg::KIND_START;
        w_mux   = '0;
        w_slot  = '0;
        w_value = '0;
        w_last  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_q_data.is_start ? S_START : S_ACC;
                end
            end
            S_ACC: begin
                w_we    = 1'b1;
                n_idx   = '0;
                n_state = r_cmd.dump ? S_DRD : S_MUX;
            end
            S_DRD: begin
                n_state = S_DOUT;
            end
            S_DOUT: begin
                w_kind  = asoa_pkg::KIND_SUM;
                w_slot  = asoa_pkg::CHAN_W'(r_idx);
                w_value = w_rval;
                if (w_out_free) begin
                    w_load = 1'b1;
                    w_clr  = 1'b1;
                    if (r_idx == AW'(NUM_SLOTS - 1)) begin
                        n_state = S_MUX;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_DRD;
                    end
                end
            end
            S_MUX: begin
                w_kind = asoa_pkg::KIND_MUX;
                w_mux  = r_cmd.chan;
                w_last = 1'b1;
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_START: begin
                w_kind = asoa_pkg::KIND_START;
                w_last = 1'b1;
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sum memory: one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_cmd_addr] <= w_rval + asoa_pkg::SUM_W'(r_cmd.sample);
        end
        r_rdata <= r_mem[w_raddr];
        r_rdv   <= r_vld[w_raddr];
    end

    // Control registers, valid bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_we) begin
                r_vld[w_cmd_addr] <= 1'b1;
            end
            if (w_clr) begin
                r_vld[r_idx] <= 1'b0;
            end
            if (w_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Hold the command and the result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_data;
        end
        if (w_load) begin
            o_kind        <= w_kind;
            o_mux_channel <= w_mux;
            o_sum_slot    <= w_slot;
            o_sum_value   <= w_value;
            o_last        <= w_last;
        end
    end

endmodule
